FILE: rtl/core/anpc_pkg.sv
package anpc_pkg;

  // Field and storage widths.
  localparam int CH_W      = 8;
  localparam int SUM_W     = 12;
  localparam int DIST_W    = 10;
  localparam int CODE_W    = 3;
  localparam int PAL_N     = 6;
  localparam int PAL_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Largest L1 distance between two 8-bit colors.
  localparam int DIST_MAX  = 765;

  typedef logic [CH_W-1:0]      chan_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [DIST_W-1:0]    dist_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [PAL_W-1:0]     color_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Palette contents after reset, packed red, green, blue.
  localparam color_t PAL_RESET [PAL_N] = '{
    24'hC83264, 24'h1EAA3C, 24'h00A0FF, 24'hAAC81E, 24'hC86432, 24'hB4B4B4
  };

endpackage

FILE: rtl/core/average_nearest_palette_classifier_unit.sv
// Averages groups of SAMPLES pixel words per channel (truncating) and classifies the
// average color against six programmable palette colors by L1 distance, the lowest
// index winning a tie. One input word is taken every cycle unless a full pipeline holds
// in_ready low; the group's sums pass the group, average, distance and output registers
// in turn. The rate is set by the per-channel accumulate adder, which takes one word per
// cycle. The average, distance and minimum-select stages are pipelined, so a group may
// complete while an earlier result still waits at the output. Palette registers are
// written through the cfg port, and indexes 6 and 7 are ignored.
module average_nearest_palette_classifier_unit #(
  parameter int SAMPLES = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration write port
  input  logic                      cfg_we,
  input  anpc_pkg::cfg_idx_t        cfg_idx,
  input  anpc_pkg::color_t          cfg_wdata,
  // Input word channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  anpc_pkg::chan_t           in_red,
  input  anpc_pkg::chan_t           in_green,
  input  anpc_pkg::chan_t           in_blue,
  // Result word channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output anpc_pkg::code_t           out_color_code,
  output anpc_pkg::chan_t           out_avg_red,
  output anpc_pkg::chan_t           out_avg_green,
  output anpc_pkg::chan_t           out_avg_blue,
  output anpc_pkg::dist_t           out_min_distance
);

  localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  // Reciprocal multiply: floor(x / SAMPLES) == (x * DIV_MUL) >> DIV_SH for 12-bit x.
  localparam int DIV_SH  = anpc_pkg::SUM_W + $clog2(SAMPLES);
  localparam int DIV_MUL = ((1 << DIV_SH) + SAMPLES - 1) / SAMPLES;
  localparam int MUL_W   = anpc_pkg::SUM_W + 2;
  localparam int PROD_W  = anpc_pkg::SUM_W + MUL_W;

  // Absolute difference of two channel values.
  function automatic anpc_pkg::chan_t abs_diff(anpc_pkg::chan_t a, anpc_pkg::chan_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // L1 distance between an average and one packed palette color.
  function automatic anpc_pkg::dist_t l1_dist(anpc_pkg::chan_t r, anpc_pkg::chan_t g,
                                              anpc_pkg::chan_t b, anpc_pkg::color_t p);
    return anpc_pkg::DIST_W'(abs_diff(r, p[23:16]))
         + anpc_pkg::DIST_W'(abs_diff(g, p[15:8]))
         + anpc_pkg::DIST_W'(abs_diff(b, p[7:0]));
  endfunction

  // Truncating division of a channel sum by SAMPLES.
  function automatic anpc_pkg::chan_t div_samples(anpc_pkg::sum_t s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(MUL_W'(DIV_MUL));
    return anpc_pkg::CH_W'(prod >> DIV_SH);
  endfunction

  anpc_pkg::color_t pal_r [anpc_pkg::PAL_N];

  anpc_pkg::sum_t   red_sum_r, green_sum_r, blue_sum_r;
  logic [CNT_W-1:0] cnt_r;

  logic             grp_vld_r;
  anpc_pkg::sum_t   grp_red_r, grp_green_r, grp_blue_r;

  logic             avg_vld_r;
  anpc_pkg::chan_t  avg_red_r, avg_green_r, avg_blue_r;

  logic             dst_vld_r;
  anpc_pkg::chan_t  dst_red_r, dst_green_r, dst_blue_r;
  anpc_pkg::dist_t  dst_r [anpc_pkg::PAL_N];

  logic             out_vld_r;
  anpc_pkg::code_t  out_code_r;
  anpc_pkg::chan_t  out_red_r, out_green_r, out_blue_r;
  anpc_pkg::dist_t  out_dist_r;

  logic             out_free, dst_free, avg_free, grp_free;
  logic             in_fire, last_word;
  anpc_pkg::sum_t   red_sum_nxt, green_sum_nxt, blue_sum_nxt;

  anpc_pkg::dist_t  min_a, min_b, min_c, min_ab, min_nxt;
  anpc_pkg::code_t  idx_a, idx_b, idx_c, idx_ab, code_nxt;

  // Stage handshake: each stage loads when it is empty or its word moves on.
  assign out_free = !out_vld_r || out_ready;
  assign dst_free = !dst_vld_r || out_free;
  assign avg_free = !avg_vld_r || dst_free;
  assign grp_free = !grp_vld_r || avg_free;
  assign in_ready = grp_free;
  assign in_fire  = in_valid && in_ready;

  assign last_word    = (cnt_r == CNT_W'(SAMPLES - 1));
  assign red_sum_nxt   = red_sum_r   + anpc_pkg::SUM_W'(in_red);
  assign green_sum_nxt = green_sum_r + anpc_pkg::SUM_W'(in_green);
  assign blue_sum_nxt  = blue_sum_r  + anpc_pkg::SUM_W'(in_blue);

  // Palette registers; writes to unused indexes fall through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < anpc_pkg::PAL_N; i++) pal_r[i] <= anpc_pkg::PAL_RESET[i];
    end else if (cfg_we) begin
      for (int i = 0; i < anpc_pkg::PAL_N; i++) begin
        if (cfg_idx == anpc_pkg::CFG_IDX_W'(i)) pal_r[i] <= cfg_wdata;
      end
    end
  end

  // Group accumulators and sample counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      cnt_r       <= '0;
    end else if (in_fire) begin
      if (last_word) begin
        red_sum_r   <= '0;
        green_sum_r <= '0;
        blue_sum_r  <= '0;
        cnt_r       <= '0;
      end else begin
        red_sum_r   <= red_sum_nxt;
        green_sum_r <= green_sum_nxt;
        blue_sum_r  <= blue_sum_nxt;
        cnt_r       <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Completed group sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
    end else if (grp_free) begin
      grp_vld_r <= in_valid && last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_word) begin
      grp_red_r   <= red_sum_nxt;
      grp_green_r <= green_sum_nxt;
      grp_blue_r  <= blue_sum_nxt;
    end
  end

  // Averages by reciprocal multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r <= 1'b0;
    end else if (avg_free) begin
      avg_vld_r <= grp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_free && grp_vld_r) begin
      avg_red_r   <= div_samples(grp_red_r);
      avg_green_r <= div_samples(grp_green_r);
      avg_blue_r  <= div_samples(grp_blue_r);
    end
  end

  // Distances to all palette colors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_vld_r <= 1'b0;
    end else if (dst_free) begin
      dst_vld_r <= avg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dst_free && avg_vld_r) begin
      dst_red_r   <= avg_red_r;
      dst_green_r <= avg_green_r;
      dst_blue_r  <= avg_blue_r;
      for (int i = 0; i < anpc_pkg::PAL_N; i++) begin
        dst_r[i] <= l1_dist(avg_red_r, avg_green_r, avg_blue_r, pal_r[i]);
      end
    end
  end

  // Minimum select; the higher index wins only when strictly closer.
  always_comb begin
    min_a = dst_r[0];
    idx_a = anpc_pkg::CODE_W'(0);
    if (dst_r[1] < dst_r[0]) begin
      min_a = dst_r[1];
      idx_a = anpc_pkg::CODE_W'(1);
    end
    min_b = dst_r[2];
    idx_b = anpc_pkg::CODE_W'(2);
    if (dst_r[3] < dst_r[2]) begin
      min_b = dst_r[3];
      idx_b = anpc_pkg::CODE_W'(3);
    end
    min_c = dst_r[4];
    idx_c = anpc_pkg::CODE_W'(4);
    if (dst_r[5] < dst_r[4]) begin
      min_c = dst_r[5];
      idx_c = anpc_pkg::CODE_W'(5);
    end
    min_ab = min_a;
    idx_ab = idx_a;
    if (min_b < min_a) begin
      min_ab = min_b;
      idx_ab = idx_b;
    end
    min_nxt  = min_ab;
    code_nxt = idx_ab;
    if (min_c < min_ab) begin
      min_nxt  = min_c;
      code_nxt = idx_c;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= dst_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && dst_vld_r) begin
      out_code_r  <= code_nxt;
      out_dist_r  <= min_nxt;
      out_red_r   <= dst_red_r;
      out_green_r <= dst_green_r;
      out_blue_r  <= dst_blue_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_color_code   = out_code_r;
  assign out_avg_red      = out_red_r;
  assign out_avg_green    = out_green_r;
  assign out_avg_blue     = out_blue_r;
  assign out_min_distance = out_dist_r;

endmodule

FILE: rtl/core/anpc_checker.sv
module anpc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input anpc_pkg::code_t      out_color_code,
  input anpc_pkg::chan_t      out_avg_red,
  input anpc_pkg::dist_t      out_min_distance
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color_code)
      && $stable(out_avg_red) && $stable(out_min_distance))
    else $error("result word changed while stalled");

  // The chosen code is always a palette index.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_code < anpc_pkg::CODE_W'(anpc_pkg::PAL_N))
    else $error("color code out of range");

  // The distance never exceeds the largest L1 distance.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_distance <= anpc_pkg::DIST_W'(anpc_pkg::DIST_MAX))
    else $error("minimum distance out of range");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind average_nearest_palette_classifier_unit anpc_checker u_anpc_checker (.*);

FILE: test/palette_class_checker.sv
module palette_class_checker #(
  parameter int SAMPLES = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  anpc_pkg::cfg_idx_t   cfg_idx,
  input  anpc_pkg::color_t     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  anpc_pkg::chan_t      in_red,
  input  anpc_pkg::chan_t      in_green,
  input  anpc_pkg::chan_t      in_blue,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  anpc_pkg::code_t      out_color_code,
  input  anpc_pkg::chan_t      out_avg_red,
  input  anpc_pkg::chan_t      out_avg_green,
  input  anpc_pkg::chan_t      out_avg_blue,
  input  anpc_pkg::dist_t      out_min_distance,
  output int                   class_mismatches,
  output int                   classes_pending,
  output int                   classes_checked
);

  localparam int REPORT_LIMIT = 10;

  // One classification word: nearest color, average color and its distance.
  typedef struct packed {
    anpc_pkg::code_t code;
    anpc_pkg::chan_t red;
    anpc_pkg::chan_t green;
    anpc_pkg::chan_t blue;
    anpc_pkg::dist_t min_dist;
  } class_word_t;

  class_word_t      expected_classes [$];
  anpc_pkg::color_t palette [anpc_pkg::PAL_N];
  anpc_pkg::sum_t   red_acc;
  anpc_pkg::sum_t   green_acc;
  anpc_pkg::sum_t   blue_acc;
  logic [3:0]       group_fill;

  function automatic int chan_gap(anpc_pkg::chan_t a, anpc_pkg::chan_t b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  always @(posedge clk) begin
    class_word_t     want;
    class_word_t     got;
    anpc_pkg::chan_t avg_r;
    anpc_pkg::chan_t avg_g;
    anpc_pkg::chan_t avg_b;
    int              gap;
    int              best_gap;
    anpc_pkg::code_t best_code;
    if (!rst_n) begin
      palette = anpc_pkg::PAL_RESET;
      red_acc = '0;
      green_acc = '0;
      blue_acc = '0;
      group_fill = '0;
      expected_classes.delete();
      class_mismatches = 0;
      classes_checked = 0;
    end else begin
      // Track palette writes; indexes past the last color are dropped.
      if (cfg_we && int'(cfg_idx) < anpc_pkg::PAL_N) begin
        palette[cfg_idx] = cfg_wdata;
      end

      // Compare a delivered word with the oldest prediction.
      if (out_valid && out_ready) begin
        got = '{out_color_code, out_avg_red, out_avg_green, out_avg_blue, out_min_distance};
        if (expected_classes.size() == 0) begin
          if (class_mismatches < REPORT_LIMIT) begin
            $display("%0t: result word with none expected: code %0d avg %02h %02h %02h dist %0d",
                     $time, got.code, got.red, got.green, got.blue, got.min_dist);
          end
          class_mismatches++;
        end else begin
          want = expected_classes.pop_front();
          classes_checked++;
          if (got.code !== want.code || got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.min_dist !== want.min_dist) begin
            if (class_mismatches < REPORT_LIMIT) begin
              $display("%0t: word mismatch, expected code %0d avg %02h %02h %02h dist %0d",
                       $time, want.code, want.red, want.green, want.blue, want.min_dist);
              $display("%0t:                got      code %0d avg %02h %02h %02h dist %0d",
                       $time, got.code, got.red, got.green, got.blue, got.min_dist);
            end
            class_mismatches++;
          end
        end
      end

      // Accumulate an accepted sample; the last one of a group yields a word.
      if (in_valid && in_ready) begin
        red_acc = red_acc + anpc_pkg::sum_t'(in_red);
        green_acc = green_acc + anpc_pkg::sum_t'(in_green);
        blue_acc = blue_acc + anpc_pkg::sum_t'(in_blue);
        if (int'(group_fill) + 1 < SAMPLES) begin
          group_fill = group_fill + 4'd1;
        end else begin
          avg_r = anpc_pkg::chan_t'(red_acc / SAMPLES);
          avg_g = anpc_pkg::chan_t'(green_acc / SAMPLES);
          avg_b = anpc_pkg::chan_t'(blue_acc / SAMPLES);
          best_gap = anpc_pkg::DIST_MAX + 1;
          best_code = '0;
          // Strict compare keeps the lowest index on a tie.
          for (int i = 0; i < anpc_pkg::PAL_N; i++) begin
            gap = chan_gap(avg_r, palette[i][23:16]) + chan_gap(avg_g, palette[i][15:8]) +
                  chan_gap(avg_b, palette[i][7:0]);
            if (gap < best_gap) begin
              best_gap = gap;
              best_code = anpc_pkg::code_t'(i);
            end
          end
          expected_classes.push_back('{best_code, avg_r, avg_g, avg_b,
                                       anpc_pkg::dist_t'(best_gap)});
          red_acc = '0;
          green_acc = '0;
          blue_acc = '0;
          group_fill = '0;
        end
      end
    end
    classes_pending = expected_classes.size();
  end

endmodule

FILE: test/testbench.sv
module testbench;

  localparam int SAMPLES        = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int IDLE_PCT       = 36;

  localparam anpc_pkg::cfg_idx_t CFG_PALETTE_0 = 3'd0;
  localparam anpc_pkg::cfg_idx_t CFG_PALETTE_1 = 3'd1;
  localparam anpc_pkg::cfg_idx_t CFG_SPARE_A   = 3'd6;
  localparam anpc_pkg::cfg_idx_t CFG_SPARE_B   = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  anpc_pkg::cfg_idx_t cfg_idx;
  anpc_pkg::color_t   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  anpc_pkg::chan_t    in_red;
  anpc_pkg::chan_t    in_green;
  anpc_pkg::chan_t    in_blue;
  logic               out_valid;
  logic               out_ready;
  anpc_pkg::code_t    out_color_code;
  anpc_pkg::chan_t    out_avg_red;
  anpc_pkg::chan_t    out_avg_green;
  anpc_pkg::chan_t    out_avg_blue;
  anpc_pkg::dist_t    out_min_distance;
  int                 class_mismatches;
  int                 classes_pending;
  int                 classes_checked;

  // Stimulus state shared by the sender and receiver processes.
  anpc_pkg::color_t pal_shadow [anpc_pkg::PAL_N];
  int               send_idle_pct = IDLE_PCT;
  int               recv_idle_pct = IDLE_PCT;
  int               hold_requests = 0;
  int               words_sent = 0;
  int               palette_loads = 0;
  int               group_style;
  anpc_pkg::color_t group_color;

  average_nearest_palette_classifier_unit #(.SAMPLES(SAMPLES)) u_dut (.*);

  palette_class_checker #(.SAMPLES(SAMPLES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic anpc_pkg::chan_t jitter(anpc_pkg::chan_t base);
    int v;
    v = int'(base) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return anpc_pkg::chan_t'(v);
  endfunction

  // Offer one sample word, with random idle cycles ahead of it.
  task automatic send_word(input anpc_pkg::chan_t r, input anpc_pkg::chan_t g,
                           input anpc_pkg::chan_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Each group gets one flavor: noise, a smear around a palette color, or saturated channels.
  task automatic send_samples(input int count);
    repeat (count) begin
      if (words_sent % SAMPLES == 0) begin
        group_style = $urandom_range(99);
        group_color = pal_shadow[$urandom_range(anpc_pkg::PAL_N - 1)];
      end
      if (group_style < 40) begin
        send_word(anpc_pkg::chan_t'($urandom), anpc_pkg::chan_t'($urandom),
                  anpc_pkg::chan_t'($urandom));
      end else if (group_style < 80) begin
        send_word(jitter(group_color[23:16]), jitter(group_color[15:8]),
                  jitter(group_color[7:0]));
      end else begin
        send_word($urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                  $urandom_range(1) ? 8'hFF : 8'h00);
      end
    end
  endtask

  // Stop offering words and wait until every predicted result has left the block.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (classes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input anpc_pkg::cfg_idx_t idx, input anpc_pkg::color_t value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (int'(idx) < anpc_pkg::PAL_N) pal_shadow[idx] = value;
  endtask

  task automatic load_palette(input anpc_pkg::color_t colors [anpc_pkg::PAL_N]);
    for (int i = 0; i < anpc_pkg::PAL_N; i++) begin
      write_reg(anpc_pkg::cfg_idx_t'(i), colors[i]);
    end
    write_reg(CFG_SPARE_A, anpc_pkg::color_t'($urandom));
    write_reg(CFG_SPARE_B, anpc_pkg::color_t'($urandom));
    cfg_we <= 1'b0;
    palette_loads++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("No word accepted for %0d cycles, run stopped", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus sequence.
  initial begin
    anpc_pkg::color_t colors [anpc_pkg::PAL_N];
    anpc_pkg::color_t shade_a;
    anpc_pkg::color_t shade_b;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    pal_shadow = anpc_pkg::PAL_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturated and black groups against the reset palette.
    repeat (SAMPLES) send_word(8'hFF, 8'hFF, 8'hFF);
    repeat (SAMPLES) send_word(8'h00, 8'h00, 8'h00);

    // Open a group, retune two colors and poke the unused indexes, then finish it.
    send_word(8'hFF, 8'h00, 8'hFF);
    send_word(8'h00, 8'hFF, 8'h00);
    send_word(8'h80, 8'h7F, 8'h01);
    drain_results();
    write_reg(CFG_PALETTE_0, 24'h000000);
    write_reg(CFG_PALETTE_1, 24'hFFFFFF);
    write_reg(CFG_SPARE_A, anpc_pkg::color_t'($urandom));
    write_reg(CFG_SPARE_B, anpc_pkg::color_t'($urandom));
    cfg_we <= 1'b0;
    repeat (SAMPLES - 3) send_word(8'hFF, 8'hFF, 8'hFF);
    send_samples(120);

    // All colors black: every group ties, and a white group hits the largest distance.
    drain_results();
    foreach (colors[i]) colors[i] = '0;
    load_palette(colors);
    repeat (SAMPLES) send_word(8'hFF, 8'hFF, 8'hFF);
    send_samples(80);

    // Two shades spread over the palette, so ties land on higher indexes too.
    drain_results();
    shade_a = anpc_pkg::color_t'($urandom);
    shade_b = anpc_pkg::color_t'($urandom);
    foreach (colors[i]) colors[i] = $urandom_range(1) ? shade_a : shade_b;
    load_palette(colors);
    send_samples(50);
    // Receiver holds off while the sender streams, so the block backs up.
    hold_requests++;
    send_idle_pct = 0;
    send_samples(100);
    send_idle_pct = IDLE_PCT;
    drain_results();
    send_samples(60);

    // Random palette with neither side idling.
    drain_results();
    foreach (colors[i]) colors[i] = anpc_pkg::color_t'($urandom);
    load_palette(colors);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_samples(150);
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    // Primary and corner colors, with a duplicated white.
    drain_results();
    colors = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};
    load_palette(colors);
    send_samples(150);

    // Back to the reset palette.
    drain_results();
    load_palette(anpc_pkg::PAL_RESET);
    send_samples(150);

    drain_results();
    $display("Sent %0d pixel words under %0d palette loads plus a mid-group retune;",
             words_sent, palette_loads);
    $display("checked %0d classification words, %0d mismatches, %0d still awaited.",
             classes_checked, class_mismatches, classes_pending);
    if (class_mismatches == 0 && classes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: average_nearest_palette_classifier_unit.f
rtl/core/anpc_pkg.sv
rtl/core/average_nearest_palette_classifier_unit.sv
rtl/core/anpc_checker.sv
test/palette_class_checker.sv
test/testbench.sv
